/* hw/rtl/handwheel_velocity_jog_assert.svh */
// Assertion macros for the handwheel jog block.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef HANDWHEEL_VELOCITY_JOG_ASSERT_SVH
`define HANDWHEEL_VELOCITY_JOG_ASSERT_SVH

`ifndef SYNTHESIS
`define HVJ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define HVJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HVJ_ASSERT(lbl, prop, msg)
`define HVJ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/hvj_pkg.sv */
package hvj_pkg;

    localparam int AXES              = 3;
    localparam int OUT_AXES          = 3;
    localparam int SHAPE_TABLE_DEPTH = 256;
    localparam int SHAPE_SPAN        = SHAPE_TABLE_DEPTH - 1;
    localparam int AXIS_W            = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int IDX_W             = $clog2(SHAPE_TABLE_DEPTH);
    localparam int ENTRY_W           = 17;
    localparam int FACTOR_W          = 14;

    // table step 1/span, only used for the first estimate of each entry
    localparam real SHAPE_INV = 1.0 / real'(SHAPE_SPAN);

    localparam logic [31:0] DECAY_Q16 = 32'd62259;
    localparam logic [16:0] SCALE_ONE = 17'd65536;

    // configuration register indexes
    localparam logic [2:0] CFG_JOG_STEP       = 3'd0;
    localparam logic [2:0] CFG_WHEEL_AXIS     = 3'd1;
    localparam logic [2:0] CFG_TICK_PERIOD    = 3'd2;
    localparam logic [2:0] CFG_COUNT_TO_SCALE = 3'd3;
    localparam logic [2:0] CFG_MAX_VELOCITY   = 3'd4;
    localparam logic [2:0] CFG_MAX_VEL_STEP   = 3'd5;

    localparam logic [2:0] JOG_STEP_MAX = 3'd4;

    typedef logic [SHAPE_TABLE_DEPTH-1:0][ENTRY_W-1:0] t_shape_rom;

    // exact test: y <= 65536 * (i / span)^0.7
    function automatic logic shape_fits(input int y, input int i);
        logic [255:0] l;
        logic [255:0] r;
        l = 256'd1;
        r = 256'd1;
        for (int n = 0; n < 7; n++) l = l * 256'(SHAPE_SPAN);
        for (int n = 0; n < 10; n++) l = l * 256'(y);
        for (int n = 0; n < 7; n++) r = r * 256'(i);
        r = r << 160;
        return (l <= r);
    endfunction

    // floor of 65536 * x^0.7, real estimate trimmed by the exact test
    function automatic t_shape_rom build_shape_rom();
        t_shape_rom rom;
        real        x;
        int         y;
        for (int i = 0; i < SHAPE_TABLE_DEPTH; i++) begin
            x = 65536.0 * ((real'(i) * SHAPE_INV) ** 0.7);
            y = $rtoi(x);
            if (y > 65536) y = 65536;
            if (y < 0) y = 0;
            for (int k = 0; k < 3; k++) begin
                if (y < 65536 && shape_fits(y + 1, i)) y = y + 1;
            end
            for (int k = 0; k < 3; k++) begin
                if (y > 0 && !shape_fits(y, i)) y = y - 1;
            end
            rom[i] = ENTRY_W'(y);
        end
        return rom;
    endfunction

    localparam t_shape_rom SHAPE_ROM = build_shape_rom();

    function automatic logic [FACTOR_W-1:0] step_factor(input logic [2:0] mode);
        case (mode)
            3'd0:    return 14'd1;
            3'd1:    return 14'd10;
            3'd2:    return 14'd100;
            3'd3:    return 14'd1000;
            default: return 14'd10000;
        endcase
    endfunction

endpackage

/* hw/rtl/handwheel_velocity_jog.sv */
// Handwheel velocity jog.
// Input channel: one beat per control tick, i_encoder_count is the raw 16-bit
// wheel count for the active axis. Taken when i_in_valid is high and
// o_in_stall is low. o_in_stall stays high while a tick is being worked.
// Output channel: one beat per tick with all three axis positions and the
// active axis velocity, held while i_out_stall is high.
// Config channel: i_cfg_index / i_cfg_data, written when i_cfg_valid and
// o_cfg_ready are high; write only while no tick is in flight.
// A no-motion tick runs the decay steps, a motion tick the scale, lookup,
// slew and integrate steps; the next tick is taken only once the sequencer
// is back in idle. All multiplies go through one registered 32x32
// multiplier, stepped by the sequencer, one product per cycle.
// A stalled output beat does not block the next input: the sequencer runs
// the next tick and waits in its final step until the output slot frees.
// Reset (synchronous, i_rst_n low): counts, velocities and positions clear
// to zero, registers take their default values, no beat is pending.
module handwheel_velocity_jog
    import hvj_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_encoder_count,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_position_x,
    output logic signed [63:0] o_position_y,
    output logic signed [63:0] o_position_z,
    output logic signed [30:0] o_active_velocity,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

`include "handwheel_velocity_jog_assert.svh"

    // sequencer steps
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECAY    = 4'd1;  // |v| * 0.95
    localparam logic [3:0] S_DECAY_WB = 4'd2;
    localparam logic [3:0] S_SCALE    = 4'd3;  // |delta| * count_to_scale
    localparam logic [3:0] S_INDEX    = 4'd4;  // s * span
    localparam logic [3:0] S_LOOKUP   = 4'd5;  // round, table read
    localparam logic [3:0] S_TARGET   = 4'd6;  // entry * range step
    localparam logic [3:0] S_CLAMP    = 4'd7;  // clamp to max, dv = target - v
    localparam logic [3:0] S_SLEW     = 4'd8;  // slew limit, new v
    localparam logic [3:0] S_STEP     = 4'd9;  // |v| * tick_period
    localparam logic [3:0] S_INTEG    = 4'd10; // position update
    localparam logic [3:0] S_DONE     = 4'd11; // load output beat

    // config registers
    logic [2:0]  r_jog_step;
    logic [1:0]  r_wheel_axis;
    logic [31:0] r_tick_period;
    logic [23:0] r_count_to_scale;
    logic [29:0] r_max_velocity;
    logic [29:0] r_max_vel_step;

    // per-axis state
    logic [15:0]        r_last  [AXES];
    logic signed [30:0] r_vmem  [AXES];
    logic [63:0]        r_pos   [AXES];

    // working registers
    logic [3:0]         r_state;
    logic [15:0]        r_raw;
    logic signed [30:0] r_vel;
    logic [ENTRY_W-1:0] r_entry;
    logic signed [31:0] r_dv;
    logic               r_out_valid;

    logic [AXIS_W-1:0]  w_ax;
    logic               w_accept;
    logic [15:0]        w_dmag;
    logic [29:0]        w_vmag;
    logic               w_mul_en;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_prod;
    logic [16:0]        w_scale;
    logic [47:0]        w_round;
    logic [31:0]        w_idx_full;
    logic [IDX_W-1:0]   w_idx;
    logic [29:0]        w_tgt_mag;
    logic signed [31:0] w_target;
    logic signed [31:0] w_lim;
    logic signed [31:0] w_dv_lim;
    logic signed [31:0] w_vel_sum;
    logic [29:0]        w_decay_mag;
    logic [47:0]        w_step_mag;
    logic [63:0]        w_pos_out [OUT_AXES];

    assign w_ax     = AXIS_W'(r_wheel_axis);
    assign w_accept = i_in_valid && !o_in_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    // magnitudes; |v| never reaches 2^30 since no target exceeds max_velocity
    assign w_dmag = r_raw[15] ? (16'd0 - r_raw) : r_raw;
    assign w_vmag = r_vel[30] ? 30'(-r_vel) : r_vel[29:0];

    // operand select for the shared multiplier
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            S_DECAY: begin
                w_mul_a = 32'(w_vmag);
                w_mul_b = DECAY_Q16;
            end
            S_SCALE: begin
                w_mul_a = 32'(w_dmag);
                w_mul_b = 32'(r_count_to_scale);
            end
            S_INDEX: begin
                w_mul_a = 32'(w_scale);
                w_mul_b = 32'(SHAPE_SPAN);
            end
            S_TARGET: begin
                w_mul_a = 32'(r_entry);
                w_mul_b = 32'(step_factor(r_jog_step));
            end
            S_STEP: begin
                w_mul_a = 32'(w_vmag);
                w_mul_b = r_tick_period;
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    hvj_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // speed scale saturates at 1.0 (Q1.16)
    assign w_scale = (w_prod > 64'(SCALE_ONE)) ? SCALE_ONE : w_prod[16:0];

    // table index with round to nearest
    assign w_round    = w_prod[47:0] + 48'd32768;
    assign w_idx_full = w_round[47:16];
    assign w_idx      = (w_idx_full > 32'(SHAPE_SPAN)) ? IDX_W'(SHAPE_SPAN)
                                                       : w_idx_full[IDX_W-1:0];

    // target and slew
    assign w_tgt_mag = (w_prod > 64'(r_max_velocity)) ? r_max_velocity : w_prod[29:0];
    assign w_target  = r_raw[15] ? -$signed({2'b00, w_tgt_mag}) : $signed({2'b00, w_tgt_mag});
    assign w_lim     = $signed({2'b00, r_max_vel_step});
    always_comb begin
        if (r_dv > w_lim) begin
            w_dv_lim = w_lim;
        end else if (r_dv < -w_lim) begin
            w_dv_lim = -w_lim;
        end else begin
            w_dv_lim = r_dv;
        end
    end
    assign w_vel_sum = 32'(r_vel) + w_dv_lim;

    assign w_decay_mag = w_prod[45:16];
    assign w_step_mag  = w_prod[63:16];

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int a = 0; a < AXES; a++) begin
                r_last[a] <= '0;
                r_vmem[a] <= '0;
                r_pos[a]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_raw        <= i_encoder_count - r_last[w_ax];
                        r_last[w_ax] <= i_encoder_count;
                        r_vel        <= r_vmem[w_ax];
                        r_state      <= (i_encoder_count == r_last[w_ax]) ? S_DECAY : S_SCALE;
                    end
                end
                S_DECAY:    r_state <= S_DECAY_WB;
                S_DECAY_WB: begin
                    r_vel        <= r_vel[30] ? -$signed({1'b0, w_decay_mag})
                                              : $signed({1'b0, w_decay_mag});
                    r_vmem[w_ax] <= r_vel[30] ? -$signed({1'b0, w_decay_mag})
                                              : $signed({1'b0, w_decay_mag});
                    r_state      <= S_DONE;
                end
                S_SCALE:  r_state <= S_INDEX;
                S_INDEX:  r_state <= S_LOOKUP;
                S_LOOKUP: begin
                    r_entry <= SHAPE_ROM[w_idx];
                    r_state <= S_TARGET;
                end
                S_TARGET: r_state <= S_CLAMP;
                S_CLAMP: begin
                    r_dv    <= w_target - 32'(r_vel);
                    r_state <= S_SLEW;
                end
                S_SLEW: begin
                    r_vel        <= 31'(w_vel_sum);
                    r_vmem[w_ax] <= 31'(w_vel_sum);
                    r_state      <= S_STEP;
                end
                S_STEP: r_state <= S_INTEG;
                S_INTEG: begin
                    if (r_vel[30]) begin
                        r_pos[w_ax] <= r_pos[w_ax] - 64'(w_step_mag);
                    end else begin
                        r_pos[w_ax] <= r_pos[w_ax] + 64'(w_step_mag);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // positions for axes that do not exist read zero
    for (genvar k = 0; k < OUT_AXES; k++) begin : g_pos_out
        if (k < AXES) begin : g_have
            assign w_pos_out[k] = r_pos[k];
        end else begin : g_none
            assign w_pos_out[k] = '0;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            o_position_x      <= w_pos_out[0];
            o_position_y      <= w_pos_out[1];
            o_position_z      <= w_pos_out[2];
            o_active_velocity <= r_vel;
        end
    end

    // config writes; out-of-range mode or axis is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jog_step       <= 3'd2;
            r_wheel_axis     <= 2'd0;
            r_tick_period    <= 32'd4294967;
            r_count_to_scale <= 24'd327680;
            r_max_velocity   <= 30'd6553600;
            r_max_vel_step   <= 30'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_JOG_STEP: begin
                    if (i_cfg_data[2:0] <= JOG_STEP_MAX) begin
                        r_jog_step <= i_cfg_data[2:0];
                    end
                end
                CFG_WHEEL_AXIS: begin
                    if (32'(i_cfg_data[1:0]) < 32'(AXES)) begin
                        r_wheel_axis <= i_cfg_data[1:0];
                    end
                end
                CFG_TICK_PERIOD:    r_tick_period    <= i_cfg_data;
                CFG_COUNT_TO_SCALE: r_count_to_scale <= i_cfg_data[23:0];
                CFG_MAX_VELOCITY:   r_max_velocity   <= i_cfg_data[29:0];
                CFG_MAX_VEL_STEP:   r_max_vel_step   <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // checks
    `HVJ_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall, "tick accepted but input not stalled")
    `HVJ_ASSERT(a_vel_in_range, (r_state != S_STEP) || (r_vel != 31'sh4000_0000), "velocity out of range")
    `HVJ_ASSERT(a_step_fits, (r_state != S_INTEG) || (w_prod[63:62] == 2'b00), "position step overflow")
    `HVJ_ASSERT(a_entry_max, (r_state != S_TARGET) || (r_entry <= 17'd65536), "shape entry above 1.0")

endmodule

/* hw/rtl/hvj_mul.sv */
// Shared 32x32 unsigned multiplier, product registered.
module hvj_mul
    import hvj_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(i_a) * 64'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

/* bench/handwheel_velocity_jog_chk.sv */
module jog_checker
    import hvj_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_encoder_count,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [63:0] i_position_x,
    input  logic signed [63:0] i_position_y,
    input  logic signed [63:0] i_position_z,
    input  logic signed [30:0] i_active_velocity,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_errors
);

    typedef struct {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] pos_z;
        logic [30:0] vel;
    } t_jog_beat;

    localparam logic [63:0] DECAY_NUM = 64'd62259;     // 0.95 in Q0.16

    // settings as the block should hold them
    logic [2:0]  jog_step;
    logic [1:0]  wheel_axis;
    logic [31:0] tick_period;
    logic [23:0] count_to_scale;
    logic [29:0] max_velocity;
    logic [29:0] max_velocity_step;

    // per-axis wheel state
    logic [15:0]        last_count [AXES];
    logic signed [31:0] axis_vel   [AXES];
    logic [63:0]        axis_pos   [AXES];

    int        shape_lut [SHAPE_TABLE_DEPTH];
    t_jog_beat expected_ticks [$];
    int        fail_count = 0;

    // floor(65536 * (i/span)^0.7), exact: y^10 * span^7 <= i^7 * 2^160
    function automatic int shape_floor(input int i);
        logic [255:0] rhs;
        logic [255:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        rhs = 256'd1;
        for (int n = 0; n < 7; n++) rhs = rhs * 256'(i);
        rhs = rhs << 160;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 256'd1;
            for (int n = 0; n < 7; n++) lhs = lhs * 256'(SHAPE_SPAN);
            for (int n = 0; n < 10; n++) lhs = lhs * 256'(mid);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    initial begin
        for (int i = 0; i < SHAPE_TABLE_DEPTH; i++) shape_lut[i] = shape_floor(i);
    end

    function automatic void clear_state();
        jog_step          = 3'd2;
        wheel_axis        = 2'd0;
        tick_period       = 32'd4294967;
        count_to_scale    = 24'd327680;
        max_velocity      = 30'd6553600;
        max_velocity_step = 30'd65536;
        for (int a = 0; a < AXES; a++) begin
            last_count[a] = '0;
            axis_vel[a]   = '0;
            axis_pos[a]   = '0;
        end
    endfunction

    function automatic void write_setting(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_JOG_STEP:       if (data[2:0] <= JOG_STEP_MAX) jog_step = data[2:0];
            CFG_WHEEL_AXIS:     if (data[1:0] < AXES) wheel_axis = data[1:0];
            CFG_TICK_PERIOD:    tick_period = data;
            CFG_COUNT_TO_SCALE: count_to_scale = data[23:0];
            CFG_MAX_VELOCITY:   max_velocity = data[29:0];
            CFG_MAX_VEL_STEP:   max_velocity_step = data[29:0];
            default: ;
        endcase
    endfunction

    // one control tick: update the active axis, return the beat it produces
    function automatic t_jog_beat jog_tick(input logic [15:0] count);
        t_jog_beat   r;
        int          ax;
        int          delta;
        int          idx;
        logic [15:0] raw;
        longint      vel;
        longint      target;
        longint      dv;
        longint      lim;
        logic [63:0] mag;
        logic [63:0] s;
        logic [63:0] tgt;
        logic [63:0] stepm;
        ax    = wheel_axis;
        raw   = count - last_count[ax];
        delta = $signed(raw);
        vel   = axis_vel[ax];
        last_count[ax] = count;
        if (delta == 0) begin
            // idle tick: decay, no integration
            mag = (vel < 0) ? -vel : vel;
            mag = (mag * DECAY_NUM) >> 16;
            vel = (vel < 0) ? -longint'(mag) : longint'(mag);
        end else begin
            mag = (delta < 0) ? -delta : delta;
            s = mag * 64'(count_to_scale);
            if (s > 64'd65536) s = 64'd65536;
            idx = int'((s * 64'(SHAPE_SPAN) + 64'd32768) >> 16);
            if (idx > SHAPE_SPAN) idx = SHAPE_SPAN;
            tgt = 64'(shape_lut[idx]) * (64'd10 ** jog_step);
            if (tgt > 64'(max_velocity)) tgt = 64'(max_velocity);
            target = (delta < 0) ? -longint'(tgt) : longint'(tgt);
            dv  = target - vel;
            lim = longint'(max_velocity_step);
            if (dv > lim) dv = lim;
            if (dv < -lim) dv = -lim;
            vel = vel + dv;
            mag = (vel < 0) ? -vel : vel;
            stepm = (mag * 64'(tick_period)) >> 16;
            if (vel < 0) axis_pos[ax] = axis_pos[ax] - stepm;
            else axis_pos[ax] = axis_pos[ax] + stepm;
        end
        axis_vel[ax] = 32'(vel);
        r.pos_x = axis_pos[0];
        r.pos_y = axis_pos[1];
        r.pos_z = axis_pos[2];
        r.vel   = axis_vel[ax][30:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_jog_beat e;
        if (!i_rst_n) begin
            clear_state();
            expected_ticks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: output beat with nothing expected, position_x %0d",
                             $time, i_position_x);
                    fail_count++;
                end else begin
                    e = expected_ticks.pop_front();
                    compare_field("position_x", e.pos_x, i_position_x);
                    compare_field("position_y", e.pos_y, i_position_y);
                    compare_field("position_z", e.pos_z, i_position_z);
                    compare_field("active_velocity", longint'($signed(e.vel)),
                                  longint'(i_active_velocity));
                end
            end
            if (i_cfg_valid && i_cfg_ready) write_setting(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) expected_ticks.push_back(jog_tick(i_encoder_count));
        end
        o_pending <= expected_ticks.size();
        o_errors  <= fail_count;
    end

endmodule

/* bench/handwheel_velocity_jog_tb.sv */
module handwheel_velocity_jog_tb;
    import hvj_pkg::*;

    // register indexes the block has no register for
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE      = 16;    // settle time after the last beat
    localparam int IDLE_LIMIT  = 4000;  // watchdog: cycles without any beat

    typedef struct packed {
        logic [2:0]  jog_step;
        logic [1:0]  axis;
        logic [31:0] tick;
        logic [23:0] cts;
        logic [29:0] vmax;
        logic [29:0] vstep;
    } t_jog_setup;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] enc_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [30:0] act_vel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int pending;
    int errors;
    int hold_req = 0;       // bumped by the sender side to ask for a long hold-off

    // stimulus bookkeeping: last count sent per axis, and the axis the wheel drives
    logic [15:0] wheel [AXES] = '{default: '0};
    int          cur_axis = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    handwheel_velocity_jog dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_encoder_count   (enc_count),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_position_x      (pos_x),
        .o_position_y      (pos_y),
        .o_position_z      (pos_z),
        .o_active_velocity (act_vel),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    jog_checker chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_encoder_count   (enc_count),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_position_x      (pos_x),
        .i_position_y      (pos_y),
        .i_position_z      (pos_z),
        .i_active_velocity (act_vel),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_errors          (errors)
    );

    // ---- config writes --------------------------------------------------
    // Leaves cfg_valid high; the caller drops it after the last write so that
    // back-to-back writes never lower and raise valid in one step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // All six registers, junk above each register's width, then writes the
    // block must ignore: out-of-range mode and axis, and at times an unmapped index.
    task automatic load_setup(input t_jog_setup su);
        write_reg(CFG_JOG_STEP,       {29'($urandom), su.jog_step});
        write_reg(CFG_WHEEL_AXIS,     {30'($urandom), su.axis});
        write_reg(CFG_TICK_PERIOD,    su.tick);
        write_reg(CFG_COUNT_TO_SCALE, {8'($urandom), su.cts});
        write_reg(CFG_MAX_VELOCITY,   {2'($urandom), su.vmax});
        write_reg(CFG_MAX_VEL_STEP,   {2'($urandom), su.vstep});
        write_reg(CFG_JOG_STEP,
                  {29'($urandom), JOG_STEP_MAX + 3'($urandom_range(1, 3))});
        write_reg(CFG_WHEEL_AXIS, {30'($urandom), 2'(AXES)});
        if ($urandom_range(0, 1) == 1)
            write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        cfg_valid <= 1'b0;
        cur_axis = su.axis;
    endtask

    function automatic t_jog_setup make_setup(input logic [2:0] r, input logic [1:0] a,
                                              input logic [31:0] t, input logic [23:0] c,
                                              input logic [29:0] v, input logic [29:0] s);
        t_jog_setup su;
        su.jog_step = r;
        su.axis     = a;
        su.tick     = t;
        su.cts      = c;
        su.vmax     = v;
        su.vstep    = s;
        return su;
    endfunction

    function automatic t_jog_setup random_setup();
        logic [31:0] t;
        logic [23:0] c;
        logic [29:0] v;
        logic [29:0] s;
        case ($urandom_range(0, 3))
            0:       t = $urandom_range(1, 100000);
            1:       t = 32'd4294967;
            2:       t = $urandom;
            default: t = $urandom_range(1000000, 50000000);
        endcase
        // mostly scales that sweep the table over small wheel moves
        c = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(1, 1500));
        v = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(1000, 70000000));
        s = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(1, 5000000));
        return make_setup(3'($urandom_range(0, JOG_STEP_MAX)),
                          2'($urandom_range(0, AXES - 1)), t, c, v, s);
    endfunction

    // ---- input beats ----------------------------------------------------
    task automatic send_tick(input logic [15:0] cnt);
        wheel[cur_axis] = cnt;
        in_valid  <= 1'b1;
        enc_count <= cnt;
        do @(posedge clk); while (in_stall);
    endtask

    // Wheel-like motion: rests (decay), small detents, fast spins, the
    // half-turn wrap case, and now and then a count from nowhere.
    function automatic logic [15:0] next_count();
        int pick;
        int d;
        pick = $urandom_range(0, 99);
        if (pick >= 95) return 16'($urandom);
        if (pick < 20) d = 0;
        else if (pick < 60) d = $urandom_range(1, 8);
        else if (pick < 80) d = $urandom_range(9, 400);
        else if (pick < 90) d = $urandom_range(401, 32767);
        else d = 32768;
        if (d != 32768 && $urandom_range(0, 1) == 1) d = -d;
        return wheel[cur_axis] + 16'(d);
    endfunction

    // bursts of random length, random gaps; sometimes no gap at all
    task automatic run_ticks(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) send_tick(next_count());
            left -= burst;
            if (left > 0 && $urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    endtask

    // stop offering, wait for every expected beat, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---- receiver: stall pattern of its own ----------------------------
    initial begin : out_stall_pattern
        int mode;
        int len;
        int hold_done;
        hold_done = 0;
        @(posedge clk);
        forever begin
            if (hold_req != hold_done) begin
                // long hold-off: the block fills and stalls its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 48);
                repeat (len) begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ---- watchdog ----------------------------------------------------------
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) idle = 0;
            else idle++;
        end
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("[handwheel_velocity_jog] ERROR");
        $finish;
    end

    // ---- stimulus and verdict ---------------------------------------------
    initial begin : stimulus
        t_jog_setup  fixed [6];
        logic [15:0] dir_x [15];
        logic [15:0] dir_z [4];

        // corners: everything but the axis at max, then at zero, then mixed
        fixed[0] = make_setup(3'd4, 2'd1, 32'hFFFF_FFFF, 24'hFF_FFFF,
                              30'h3FFF_FFFF, 30'h3FFF_FFFF);
        fixed[1] = make_setup(3'd0, 2'd2, 32'd0, 24'd0, 30'd0, 30'd0);
        fixed[2] = make_setup(3'd1, 2'd0, 32'd1, 24'd1, 30'd1000, 30'h3FFF_FFFF);
        fixed[3] = make_setup(3'd3, 2'd1, 32'd4294967, 24'd218, 30'd6553600, 30'd65536);
        fixed[4] = make_setup(3'd4, 2'd2, 32'd42949673, 24'd1000,
                              30'h3FFF_FFFF, 30'd3000000);
        fixed[5] = make_setup(3'd2, 2'd0, 32'd4294967, 24'd327680, 30'd6553600, 30'd65536);

        // X: rest at zero, single detents both ways, the half-turn wrap,
        // all-ones and alternating patterns, repeated counts for decay
        dir_x = '{16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'hAAAA,
                  16'hFFFF, 16'hFFFE, 16'hFFFE};
        // Z: full negative half turn, rest, then tiny moves
        dir_z = '{16'h8000, 16'h8000, 16'h8001, 16'h8000};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        load_setup(make_setup(3'd2, 2'd0, 32'd4294967, 24'd218, 30'd6553600, 30'd2000000));
        foreach (dir_x[i]) send_tick(dir_x[i]);
        drain();
        load_setup(make_setup(3'd3, 2'd2, 32'd4294967, 24'd218, 30'd6553600, 30'd2000000));
        foreach (dir_z[i]) send_tick(dir_z[i]);
        drain();

        foreach (fixed[i]) begin
            load_setup(fixed[i]);
            if (i == 3) hold_req <= hold_req + 1;
            run_ticks(100);
            drain();
        end

        for (int p = 0; p < 10; p++) begin
            load_setup(random_setup());
            if (p == 4) hold_req <= hold_req + 1;
            run_ticks(105);
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("[handwheel_velocity_jog] OK");
        end else begin
            $display("[handwheel_velocity_jog] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hvj_pkg.sv
hw/rtl/hvj_mul.sv
hw/rtl/handwheel_velocity_jog.sv
bench/handwheel_velocity_jog_chk.sv
bench/handwheel_velocity_jog_tb.sv
